>>> rtl/lcar_pkg.sv
// Package for the load cell ADC reader: sample width, frame phases and the
// per-tick result of the serial frame sequencer. No dependencies.
`timescale 1ns / 1ps
package lcar_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int PULSE_TOTAL = SAMPLE_BITS + 1;
  localparam int TICK_W      = 16;
  localparam int PULSE_W     = $clog2(PULSE_TOTAL + 1);
  localparam int WEIGHT_W    = SAMPLE_BITS + 1;
  localparam int CFG_W       = 24;
  localparam int CFG_IDX_W   = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR    = 2'd2;

  // reset values of the configuration registers
  localparam logic [TICK_W-1:0]      CLOCK_LOW_RESET  = 16'd200;
  localparam logic [TICK_W-1:0]      CLOCK_HIGH_RESET = 16'd1;
  localparam logic [SAMPLE_BITS-1:0] DIVISOR_RESET    = 24'd430;

  // frame phases
  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MSB = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // what one tick of the frame sequencer produces
  typedef struct packed {
    logic                   sck;
    logic                   finish;
    logic [SAMPLE_BITS-1:0] raw;
  } frame_out_t;

endpackage

>>> rtl/load_cell_adc_reader.sv
// Load cell ADC reader (two-wire 24-bit bridge converter), one channel. Each input
// transfer is one timebase tick with the sampled DOUT level; each tick gives
// exactly one output transfer with the SCK level to drive, the running weight and
// the tare status. Ticks that do not end a frame are registered straight into the
// output register, so a new tick can be taken every cycle while no division runs and
// the output register is free. The tick that ends a frame (after the last clock pulse)
// starts a division once a tare is held, and input stays blocked until its result is
// loaded: the restoring divider resolves one quotient bit per cycle for 24 bits, then
// signals done.
// The first frame after reset is stored as the tare and gives no weight.
// Depends on lcar_pkg, lcar_frame and lcar_divider.
`timescale 1ns / 1ps
module load_cell_adc_reader (
  input  logic                                 clk,
  input  logic                                 rst,
  // tick input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 dout_level,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 sck_level,
  output logic                                 weight_valid,
  output logic signed [lcar_pkg::WEIGHT_W-1:0] weight,
  output logic                                 tare_captured,
  // configuration writes
  input  logic                                 cfg_write,
  input  logic [lcar_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lcar_pkg::CFG_W-1:0]           cfg_data
);

  localparam int N = lcar_pkg::SAMPLE_BITS;

  // configuration registers
  logic [lcar_pkg::TICK_W-1:0] clock_low_ticks;
  logic [lcar_pkg::TICK_W-1:0] clock_high_ticks;
  logic [N-1:0]                scale_divisor;

  // block state
  logic                                 busy;
  logic [N-1:0]                         no_load_value;
  logic                                 tare_flag;
  logic signed [lcar_pkg::WEIGHT_W-1:0] weight_register;

  logic                                 accept;
  lcar_pkg::frame_out_t                 fo;
  logic                                 div_start;
  logic                                 div_done;
  logic signed [lcar_pkg::WEIGHT_W-1:0] div_quotient;
  logic [N:0]                           diff;
  logic [N:0]                           diff_abs;
  logic                                 out_taken;

  // accept a tick when no division is running and the output register frees up
  assign in_ready  = !busy && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_taken = out_valid && out_ready;

  // configuration: plain writes, out-of-range indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_low_ticks  <= lcar_pkg::CLOCK_LOW_RESET;
      clock_high_ticks <= lcar_pkg::CLOCK_HIGH_RESET;
      scale_divisor    <= lcar_pkg::DIVISOR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        lcar_pkg::REG_CLOCK_LOW:  clock_low_ticks  <= cfg_data[lcar_pkg::TICK_W-1:0];
        lcar_pkg::REG_CLOCK_HIGH: clock_high_ticks <= cfg_data[lcar_pkg::TICK_W-1:0];
        lcar_pkg::REG_DIVISOR:    scale_divisor    <= cfg_data[N-1:0];
        default: ;
      endcase
    end
  end

  lcar_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .dout       (dout_level),
    .low_ticks  (clock_low_ticks),
    .high_ticks (clock_high_ticks),
    .fo         (fo)
  );

  // tared difference, split into sign and magnitude for the divider
  assign diff      = {1'b0, fo.raw} - {1'b0, no_load_value};
  assign diff_abs  = diff[N] ? -diff : diff;
  assign div_start = accept && fo.finish && tare_flag;

  lcar_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .magnitude (diff_abs[N-1:0]),
    .negative  (diff[N]),
    .divisor   (scale_divisor),
    .done      (div_done),
    .quotient  (div_quotient)
  );

  // control: busy flag, tare capture, output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      tare_flag       <= 1'b0;
      weight_register <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (div_start) begin
        // hold the tick until the quotient is ready
        busy <= 1'b1;
        if (out_taken)
          out_valid <= 1'b0;
      end else if (accept) begin
        out_valid <= 1'b1;
        if (fo.finish)
          tare_flag <= 1'b1;
      end else if (div_done) begin
        busy            <= 1'b0;
        weight_register <= div_quotient;
        out_valid       <= 1'b1;
      end else if (out_taken) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: tare value and output register
  always_ff @(posedge clk) begin
    if (accept && fo.finish && !tare_flag)
      no_load_value <= fo.raw;
    if (div_done) begin
      sck_level     <= 1'b0;
      weight_valid  <= 1'b1;
      weight        <= div_quotient;
      tare_captured <= 1'b1;
    end else if (accept && !div_start) begin
      sck_level     <= fo.sck;
      weight_valid  <= 1'b0;
      weight        <= weight_register;
      tare_captured <= tare_flag || fo.finish;
    end
  end

endmodule

>>> rtl/lcar_divider.sv
// Iterative restoring divider for the tared reading: one quotient bit per cycle,
// signed result truncated toward zero. Depends on lcar_pkg.
`timescale 1ns / 1ps
module lcar_divider (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [lcar_pkg::SAMPLE_BITS-1:0]     magnitude,
  input  logic                                 negative,
  input  logic [lcar_pkg::SAMPLE_BITS-1:0]     divisor,
  output logic                                 done,
  output logic signed [lcar_pkg::WEIGHT_W-1:0] quotient
);

  localparam int N     = lcar_pkg::SAMPLE_BITS;
  localparam int CNT_W = $clog2(N);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(N - 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [N-1:0]     rem;
  logic [N-1:0]     quo;
  logic [N-1:0]     dv;
  logic             neg;
  logic [N:0]       trial;
  logic [N:0]       diff;
  logic             fits;
  logic [N-1:0]     rem_next;
  logic [N-1:0]     quo_next;

  // shared subtract and compare: one quotient bit
  always_comb begin
    trial    = {rem, quo[N-1]};
    diff     = trial - {1'b0, dv};
    fits     = (trial >= {1'b0, dv});
    rem_next = fits ? diff[N-1:0] : trial[N-1:0];
    quo_next = {quo[N-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && !start && (count == LAST);
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == LAST)
          busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= magnitude;
      neg <= negative;
      dv  <= (divisor == '0) ? N'(1) : divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule

>>> rtl/lcar_frame.sv
// Serial frame sequencer: waits for the converter, times the clock pulses and
// shifts in the sample, one step per timebase tick. Depends on lcar_pkg.
`timescale 1ns / 1ps
module lcar_frame (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic                              dout,
  input  logic [lcar_pkg::TICK_W-1:0]       low_ticks,
  input  logic [lcar_pkg::TICK_W-1:0]       high_ticks,
  output lcar_pkg::frame_out_t              fo
);

  localparam int N = lcar_pkg::SAMPLE_BITS;

  logic [1:0]                        phase, phase_next;
  logic [lcar_pkg::PULSE_W-1:0]      pulse_index, pulse_index_next;
  logic [lcar_pkg::TICK_W-1:0]       tick_counter, tick_counter_next;
  logic [N-1:0]                      shift_value, shift_value_next;
  logic [lcar_pkg::PULSE_W-1:0]      pulse_inc;

  always_comb begin
    phase_next        = phase;
    pulse_index_next  = pulse_index;
    tick_counter_next = tick_counter;
    shift_value_next  = shift_value;
    pulse_inc         = pulse_index + 1'b1;
    fo.sck            = 1'b0;
    fo.finish         = 1'b0;
    fo.raw            = shift_value ^ lcar_pkg::SAMPLE_MSB;
    case (phase)
      lcar_pkg::PH_LOW: begin
        if (tick_counter >= low_ticks) begin
          phase_next        = lcar_pkg::PH_HIGH;
          tick_counter_next = lcar_pkg::TICK_W'(1);
          fo.sck            = 1'b1;
        end else begin
          tick_counter_next = tick_counter + 1'b1;
        end
      end
      lcar_pkg::PH_HIGH: begin
        if (tick_counter >= high_ticks) begin
          if (pulse_index < lcar_pkg::PULSE_W'(N))
            shift_value_next = {shift_value[N-2:0], dout};
          if (pulse_inc >= lcar_pkg::PULSE_W'(lcar_pkg::PULSE_TOTAL)) begin
            fo.finish         = 1'b1;
            phase_next        = lcar_pkg::PH_WAIT;
            pulse_index_next  = '0;
            tick_counter_next = '0;
          end else begin
            phase_next        = lcar_pkg::PH_LOW;
            pulse_index_next  = pulse_inc;
            tick_counter_next = lcar_pkg::TICK_W'(1);
          end
        end else begin
          tick_counter_next = tick_counter + 1'b1;
          fo.sck            = 1'b1;
        end
      end
      default: begin
        phase_next = lcar_pkg::PH_WAIT;
        if (!dout) begin
          phase_next        = lcar_pkg::PH_LOW;
          pulse_index_next  = '0;
          shift_value_next  = '0;
          tick_counter_next = lcar_pkg::TICK_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= lcar_pkg::PH_WAIT;
      pulse_index  <= '0;
      tick_counter <= '0;
      shift_value  <= '0;
    end else if (step) begin
      phase        <= phase_next;
      pulse_index  <= pulse_index_next;
      tick_counter <= tick_counter_next;
      shift_value  <= shift_value_next;
    end
  end

endmodule

>>> tb/sv/testbench.sv
// Testbench for load_cell_adc_reader: feeds DOUT ticks and register writes, predicts each
// per-tick result (SCK level, weight, tare status) with a local frame model, checks in order.
// Depends on lcar_pkg and the load_cell_adc_reader RTL.
`timescale 1ns / 1ps
module testbench;

  localparam int LIMIT = 4_000_000;
  // index 3 is not a register; writes to it must be dropped
  localparam logic [lcar_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {STEP_TICK, STEP_WRITE, STEP_DRAIN} step_kind_t;

  // one entry of the stimulus plan: a tick, a register write, or a pause until drained
  typedef struct {
    step_kind_t                     kind;
    logic                           dout;
    logic [lcar_pkg::CFG_IDX_W-1:0] idx;
    logic [lcar_pkg::CFG_W-1:0]     data;
  } plan_step_t;

  // what the block must present for one tick
  typedef struct packed {
    logic                          sck;
    logic                          weight_valid;
    logic [lcar_pkg::WEIGHT_W-1:0] weight;
    logic                          tare;
  } reading_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic                                 dout_level = 1'b1;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic                                 sck_level;
  logic                                 weight_valid;
  logic signed [lcar_pkg::WEIGHT_W-1:0] weight;
  logic                                 tare_captured;
  logic                                 cfg_write = 1'b0;
  logic [lcar_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [lcar_pkg::CFG_W-1:0]           cfg_data = '0;

  load_cell_adc_reader dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .dout_level   (dout_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sck_level    (sck_level),
    .weight_valid (weight_valid),
    .weight       (weight),
    .tare_captured(tare_captured),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  plan_step_t tick_plan[$];
  reading_t   owed_readings[$];

  // register view used while building the plan, so frame data lands on the sampling ticks
  int plan_low  = lcar_pkg::CLOCK_LOW_RESET;
  int plan_high = lcar_pkg::CLOCK_HIGH_RESET;

  // predicted registers and frame state
  logic [lcar_pkg::TICK_W-1:0]          rd_low_ticks;
  logic [lcar_pkg::TICK_W-1:0]          rd_high_ticks;
  logic [lcar_pkg::SAMPLE_BITS-1:0]     rd_divisor;
  logic [1:0]                           rd_phase;
  logic [lcar_pkg::PULSE_W-1:0]         rd_pulse;
  logic [lcar_pkg::TICK_W-1:0]          rd_count;
  logic [lcar_pkg::SAMPLE_BITS-1:0]     rd_shift;
  logic [lcar_pkg::SAMPLE_BITS-1:0]     rd_tare;
  logic                                 rd_tare_held;
  logic signed [lcar_pkg::WEIGHT_W-1:0] rd_weight;

  int       mismatch_count = 0;
  int       results_seen = 0;
  int       cycle_count = 0;
  int       send_gap = 0;
  int       send_quiet = 0;
  int       recv_hold = 0;
  int       recv_quiet = 0;
  reading_t want;

  // Short gaps most of the time, now and then a long one.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic int pick_ticks();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r < 12) return 1;
    if (r < 17) return 2;
    return $urandom_range(3, 5);
  endfunction

  // Ticks per SCK pulse under the planned registers; a zero count acts as one.
  function automatic int frame_period();
    return (plan_low == 0 ? 1 : plan_low) + (plan_high == 0 ? 1 : plan_high);
  endfunction

  task automatic plan_tick(input logic d);
    tick_plan.push_back('{kind: STEP_TICK, dout: d, idx: '0, data: '0});
  endtask

  task automatic plan_write(input logic [lcar_pkg::CFG_IDX_W-1:0] idx,
                            input logic [lcar_pkg::CFG_W-1:0] data);
    tick_plan.push_back('{kind: STEP_WRITE, dout: 1'b1, idx: idx, data: data});
    case (idx)
      lcar_pkg::REG_CLOCK_LOW:  plan_low  = int'(data[lcar_pkg::TICK_W-1:0]);
      lcar_pkg::REG_CLOCK_HIGH: plan_high = int'(data[lcar_pkg::TICK_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic plan_drain();
    tick_plan.push_back('{kind: STEP_DRAIN, dout: 1'b1, idx: '0, data: '0});
  endtask

  // One full frame that reads back as raw: a few not-ready ticks, the ready tick, then
  // 25 pulses. Only the tick where SCK falls is sampled, so every other tick carries noise.
  task automatic plan_frame(input logic [lcar_pkg::SAMPLE_BITS-1:0] raw, input int idle);
    int p;
    logic [lcar_pkg::SAMPLE_BITS-1:0] bits;
    p = frame_period();
    bits = raw ^ lcar_pkg::SAMPLE_MSB;
    repeat (idle) plan_tick(1'b1);
    plan_tick(1'b0);
    for (int t = 1; t <= lcar_pkg::PULSE_TOTAL * p; t++) begin
      if (t % p == 0 && t / p <= lcar_pkg::SAMPLE_BITS)
        plan_tick(bits[lcar_pkg::SAMPLE_BITS - t / p]);
      else
        plan_tick(1'($urandom_range(0, 1)));
    end
  endtask

  // Hold DOUT high long enough to run out any frame in progress and park in the wait phase.
  task automatic plan_flush();
    repeat (lcar_pkg::PULSE_TOTAL * frame_period() + 2) plan_tick(1'b1);
  endtask

  // Predict one tick of the reader and return what it must show for it.
  function automatic reading_t step_reader(input logic d);
    reading_t                         r;
    logic [lcar_pkg::SAMPLE_BITS-1:0] raw;
    int                               diff;
    int                               dv;
    r = '0;
    case (rd_phase)
      lcar_pkg::PH_LOW: begin
        if (rd_count >= rd_low_ticks) begin
          rd_phase = lcar_pkg::PH_HIGH;
          rd_count = lcar_pkg::TICK_W'(1);
          r.sck = 1'b1;
        end else begin
          rd_count = rd_count + 1'b1;
        end
      end
      lcar_pkg::PH_HIGH: begin
        if (rd_count >= rd_high_ticks) begin
          // falling edge: sample DOUT for the data pulses, the last pulse only sets gain
          if (rd_pulse < lcar_pkg::SAMPLE_BITS)
            rd_shift = {rd_shift[lcar_pkg::SAMPLE_BITS-2:0], d};
          rd_pulse = rd_pulse + 1'b1;
          if (rd_pulse >= lcar_pkg::PULSE_TOTAL) begin
            raw = rd_shift ^ lcar_pkg::SAMPLE_MSB;
            if (!rd_tare_held) begin
              // first frame after reset becomes the no-load reading
              rd_tare = raw;
              rd_tare_held = 1'b1;
            end else begin
              diff = int'(raw) - int'(rd_tare);
              dv = (rd_divisor == 0) ? 1 : int'(rd_divisor);
              rd_weight = lcar_pkg::WEIGHT_W'(diff / dv);
              r.weight_valid = 1'b1;
            end
            rd_phase = lcar_pkg::PH_WAIT;
            rd_pulse = '0;
            rd_count = '0;
          end else begin
            rd_phase = lcar_pkg::PH_LOW;
            rd_count = lcar_pkg::TICK_W'(1);
          end
        end else begin
          rd_count = rd_count + 1'b1;
          r.sck = 1'b1;
        end
      end
      default: begin
        rd_phase = lcar_pkg::PH_WAIT;
        if (!d) begin
          // converter ready: this tick is the first low tick of pulse one
          rd_phase = lcar_pkg::PH_LOW;
          rd_pulse = '0;
          rd_shift = '0;
          rd_count = lcar_pkg::TICK_W'(1);
        end
      end
    endcase
    r.weight = rd_weight;
    r.tare = rd_tare_held;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("MISMATCH result %0d %s: got %0d, expected %0d", results_seen, what, got,
               exp_val);
  endtask

  // Driver: advance the plan, one tick transfer or register write at a time.
  always @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      cfg_write     <= 1'b0;
      send_gap      <= 0;
      rd_low_ticks  = lcar_pkg::CLOCK_LOW_RESET;
      rd_high_ticks = lcar_pkg::CLOCK_HIGH_RESET;
      rd_divisor    = lcar_pkg::DIVISOR_RESET;
      rd_phase      = lcar_pkg::PH_WAIT;
      rd_pulse      = '0;
      rd_count      = '0;
      rd_shift      = '0;
      rd_tare       = '0;
      rd_tare_held  = 1'b0;
      rd_weight     = '0;
    end else begin
      // a write issued last cycle lands at this edge
      if (cfg_write) begin
        case (cfg_index)
          lcar_pkg::REG_CLOCK_LOW:  rd_low_ticks  = cfg_data[lcar_pkg::TICK_W-1:0];
          lcar_pkg::REG_CLOCK_HIGH: rd_high_ticks = cfg_data[lcar_pkg::TICK_W-1:0];
          lcar_pkg::REG_DIVISOR:    rd_divisor    = cfg_data[lcar_pkg::SAMPLE_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) owed_readings.push_back(step_reader(dout_level));

      // hold valid and payload while the tick waits for ready
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          in_valid  <= 1'b0;
          cfg_write <= 1'b0;
          send_gap  <= send_gap - 1;
        end else if (tick_plan.size() == 0) begin
          in_valid  <= 1'b0;
          cfg_write <= 1'b0;
        end else begin
          case (tick_plan[0].kind)
            STEP_TICK: begin
              in_valid   <= 1'b1;
              dout_level <= tick_plan[0].dout;
              cfg_write  <= 1'b0;
              tick_plan.delete(0);
              if (send_quiet > 0) begin
                send_quiet <= send_quiet - 1;
              end else begin
                send_gap <= idle_span();
                if ($urandom_range(0, 39) == 0) send_quiet <= $urandom_range(20, 150);
              end
            end
            STEP_WRITE: begin
              in_valid <= 1'b0;
              // write only once every owed result is back
              if (owed_readings.size() == 0) begin
                cfg_write <= 1'b1;
                cfg_index <= tick_plan[0].idx;
                cfg_data  <= tick_plan[0].data;
                tick_plan.delete(0);
              end else begin
                cfg_write <= 1'b0;
              end
            end
            default: begin
              in_valid  <= 1'b0;
              cfg_write <= 1'b0;
              if (owed_readings.size() == 0) tick_plan.delete(0);
            end
          endcase
        end
      end
    end
  end

  // Monitor: check every result transfer against the oldest prediction, stall at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      recv_hold  <= 0;
      recv_quiet <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (owed_readings.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = owed_readings.pop_front();
          if (sck_level !== want.sck)
            report_mismatch("sck_level", int'(sck_level), int'(want.sck));
          if (weight_valid !== want.weight_valid)
            report_mismatch("weight_valid", int'(weight_valid), int'(want.weight_valid));
          if (weight !== want.weight)
            report_mismatch("weight", int'(weight), int'($signed(want.weight)));
          if (tare_captured !== want.tare)
            report_mismatch("tare_captured", int'(tare_captured), int'(want.tare));
        end
      end
      if (recv_hold > 0) begin
        out_ready <= 1'b0;
        recv_hold <= recv_hold - 1;
      end else begin
        out_ready <= 1'b1;
        if (recv_quiet > 0) begin
          recv_quiet <= recv_quiet - 1;
        end else begin
          recv_hold <= idle_span();
          if ($urandom_range(0, 39) == 0) recv_quiet <= $urandom_range(20, 150);
        end
      end
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [lcar_pkg::SAMPLE_BITS-1:0] raw;
    logic [lcar_pkg::CFG_W-1:0]       dv;
    int                               frames;
    int                               base;

    // Tare: start a frame under the reset registers, check that SCK stays low well into
    // the long low time, then speed the clock up and run the frame out with DOUT high.
    // Every data bit reads high, so the no-load reading is 0x7FFFFF.
    plan_tick(1'b1);
    plan_tick(1'b1);
    plan_tick(1'b0);
    repeat (30) plan_tick(1'($urandom_range(0, 1)));
    plan_write(lcar_pkg::REG_CLOCK_LOW, 24'd1);
    plan_flush();
    plan_drain();

    // Reset divisor on a full-scale reading.
    plan_frame(24'hFFFFFF, 0);

    // Truncation toward zero on both sides of the tare.
    plan_write(lcar_pkg::REG_DIVISOR, 24'd3);
    plan_frame(24'h7FFFF8, 0);
    plan_frame(24'h800006, 1);

    // Largest divisor: the reading truncates to zero.
    plan_write(lcar_pkg::REG_DIVISOR, 24'hFFFFFF);
    plan_frame(24'hFFFFFF, 0);

    // Zero divisor and zero tick counts act as one.
    plan_write(lcar_pkg::REG_CLOCK_LOW, 24'd0);
    plan_write(lcar_pkg::REG_CLOCK_HIGH, 24'd0);
    plan_write(lcar_pkg::REG_DIVISOR, 24'd0);
    plan_frame(24'h000000, 2);

    // Unused index is dropped; then a longer high time.
    plan_write(REG_UNUSED, 24'hFFFFFF);
    plan_write(lcar_pkg::REG_CLOCK_LOW, 24'd1);
    plan_write(lcar_pkg::REG_CLOCK_HIGH, 24'd2);
    plan_frame(24'($urandom), 3);

    // Shorten the low time in the middle of a frame stuck at the longest low time;
    // the upper data bits must be masked off.
    plan_write(lcar_pkg::REG_CLOCK_HIGH, 24'd1);
    plan_write(lcar_pkg::REG_CLOCK_LOW, 24'hFFFFFF);
    plan_tick(1'b0);
    repeat (6) plan_tick(1'($urandom_range(0, 1)));
    plan_write(lcar_pkg::REG_CLOCK_LOW, 24'd1);
    plan_flush();

    // Same for the high time.
    plan_write(lcar_pkg::REG_CLOCK_LOW, 24'd1);
    plan_write(lcar_pkg::REG_CLOCK_HIGH, 24'h00FFFF);
    plan_tick(1'b0);
    repeat (8) plan_tick(1'($urandom_range(0, 1)));
    plan_write(lcar_pkg::REG_CLOCK_HIGH, 24'd1);
    plan_flush();

    // Random part: mostly well-formed frames with random data, some broken ones.
    frames = 0;
    base = tick_plan.size();
    while (tick_plan.size() - base < 60 || frames < 2) begin
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 1) == 0)
          plan_write(lcar_pkg::REG_CLOCK_LOW, {8'($urandom), 16'(pick_ticks())});
        if ($urandom_range(0, 1) == 0)
          plan_write(lcar_pkg::REG_CLOCK_HIGH, {8'($urandom), 16'(pick_ticks())});
        case ($urandom_range(0, 4))
          0:       dv = 24'($urandom_range(1, 16));
          1:       dv = 24'($urandom_range(17, 4096));
          2:       dv = '0;
          default: dv = 24'($urandom);
        endcase
        plan_write(lcar_pkg::REG_DIVISOR, dv);
      end
      if ($urandom_range(0, 7) == 0) plan_drain();
      if ($urandom_range(0, 6) == 0) begin
        // noise: random DOUT, frames cut off anywhere, then park again
        repeat ($urandom_range(5, 60)) plan_tick(1'($urandom_range(0, 1)));
        plan_flush();
      end else begin
        case ($urandom_range(0, 7))
          0:       raw = 24'h000000;
          1:       raw = 24'hFFFFFF;
          2:       raw = lcar_pkg::SAMPLE_MSB + 24'($urandom_range(0, 64)) - 24'd32;
          default: raw = 24'($urandom);
        endcase
        plan_frame(raw, $urandom_range(0, 3));
        frames++;
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Wait for the plan to run out and every owed result to come back.
    while (tick_plan.size() != 0 || in_valid || cfg_write || owed_readings.size() != 0)
      @(negedge clk);
    // Leave room for a late or extra result, a divide included.
    repeat (60) @(posedge clk);

    if (mismatch_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
